// ----- sv/fcc_pkg.sv -----
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types and constants for the six-plane frustum classifier.
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam int NUM_PLANES  = 6;
    localparam int NUM_AXES    = 3;
    localparam int COORD_W     = 16;
    localparam int RADIUS_W    = 15;
    localparam int PLANE_W     = 64;
    localparam int PROD_W      = 2 * COORD_W;
    // three products plus the scaled offset fit one bit above a product
    localparam int DIST_W      = PROD_W + 1;
    localparam int FRAC_SHIFT  = 14;
    localparam int PADDR_W     = 6;
    localparam int PINDEX_W    = 3;

    // test kinds
    localparam logic [1:0] CMD_POINT  = 2'd0;
    localparam logic [1:0] CMD_SPHERE = 2'd1;
    localparam logic [1:0] CMD_BOX    = 2'd2;

    // verdict codes
    localparam logic [1:0] VERDICT_INSIDE     = 2'd0;
    localparam logic [1:0] VERDICT_INTERSECTS = 2'd1;
    localparam logic [1:0] VERDICT_OUTSIDE    = 2'd2;

    // register indexes
    localparam logic [PINDEX_W-1:0] REG_LEFT   = 3'd0;
    localparam logic [PINDEX_W-1:0] REG_RIGHT  = 3'd1;
    localparam logic [PINDEX_W-1:0] REG_BOTTOM = 3'd2;
    localparam logic [PINDEX_W-1:0] REG_TOP    = 3'd3;
    localparam logic [PINDEX_W-1:0] REG_NEAR   = 3'd4;
    localparam logic [PINDEX_W-1:0] REG_FAR    = 3'd5;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIST_W-1:0]  dist_t;
    typedef logic [PLANE_W-1:0]        plane_t;

    // per-plane test outcomes
    typedef struct packed {
        logic pt_below;    // point distance below zero
        logic sph_out;     // distance below minus radius
        logic sph_cross;   // absolute distance below radius
        logic box_all;     // every corner below zero
        logic box_any;     // some corner below zero
    } plane_flags_t;

endpackage

// ----- sv/fcc_regs.sv -----
// ----------------------------------------------------------------------------
// fcc_regs
// APB register file holding the six packed plane words.
// ----------------------------------------------------------------------------
module fcc_regs
    import fcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PLANE_W-1:0] pwdata,
    output logic [PLANE_W-1:0] prdata,
    output logic               pready,
    output plane_t             planes [NUM_PLANES]
);

    logic [PINDEX_W-1:0] index;
    logic                wr_en;
    plane_t              plane_reg [NUM_PLANES];

    assign index  = paddr[PADDR_W-1:PADDR_W-PINDEX_W];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // write the addressed plane; drop writes beyond the last register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                if (index == PINDEX_W'(i))
                begin
                    plane_reg[i] <= pwdata;
                end
            end
        end
    end

    // read back
    always_comb
    begin
        unique case (index)
            REG_LEFT:   prdata = plane_reg[0];
            REG_RIGHT:  prdata = plane_reg[1];
            REG_BOTTOM: prdata = plane_reg[2];
            REG_TOP:    prdata = plane_reg[3];
            REG_NEAR:   prdata = plane_reg[4];
            REG_FAR:    prdata = plane_reg[5];
            default:    prdata = '0;
        endcase
    end

    assign planes = plane_reg;

endmodule

// ----- sv/fcc_plane_unit.sv -----
// ----------------------------------------------------------------------------
// fcc_plane_unit
// Distance datapath for one plane: products, then sums, then compares.
// ----------------------------------------------------------------------------
module fcc_plane_unit
    import fcc_pkg::*;
(
    input  logic         clk,
    input  plane_t       plane,
    input  coord_t       lo [NUM_AXES],
    input  coord_t       hi [NUM_AXES],
    input  dist_t        rs,
    output plane_flags_t flags
);

    logic signed [PROD_W-1:0] prod_lo_reg [NUM_AXES];
    logic signed [PROD_W-1:0] prod_hi_reg [NUM_AXES];
    dist_t                    d_scaled_reg;
    dist_t                    dpt_next, dmax_next, dmin_next;
    dist_t                    dpt_reg,  dmax_reg,  dmin_reg;
    dist_t                    neg_rs;
    coord_t                   coef [NUM_AXES];
    coord_t                   d_word;

    assign coef[0] = plane[15:0];
    assign coef[1] = plane[31:16];
    assign coef[2] = plane[47:32];
    assign d_word  = plane[63:48];

    // stage: one multiply per axis for each box bound
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            prod_lo_reg[k] <= PROD_W'(coef[k] * lo[k]);
            prod_hi_reg[k] <= PROD_W'(coef[k] * hi[k]);
        end
        d_scaled_reg <= {{(DIST_W-COORD_W-FRAC_SHIFT){d_word[COORD_W-1]}}, d_word,
                         {FRAC_SHIFT{1'b0}}};
    end

    // pick the farthest and nearest corner per axis; the sum separates by axis
    always_comb
    begin
        dpt_next  = d_scaled_reg;
        dmax_next = d_scaled_reg;
        dmin_next = d_scaled_reg;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            dpt_next = dpt_next + DIST_W'(prod_lo_reg[k]);
            if (prod_hi_reg[k] > prod_lo_reg[k])
            begin
                dmax_next = dmax_next + DIST_W'(prod_hi_reg[k]);
                dmin_next = dmin_next + DIST_W'(prod_lo_reg[k]);
            end
            else
            begin
                dmax_next = dmax_next + DIST_W'(prod_lo_reg[k]);
                dmin_next = dmin_next + DIST_W'(prod_hi_reg[k]);
            end
        end
    end

    // stage: plane distances
    always_ff @(posedge clk)
    begin
        dpt_reg  <= dpt_next;
        dmax_reg <= dmax_next;
        dmin_reg <= dmin_next;
    end

    assign neg_rs = -rs;

    // compare against zero and the scaled radius
    always_comb
    begin
        flags.pt_below  = dpt_reg < 0;
        flags.sph_out   = dpt_reg < neg_rs;
        flags.sph_cross = (dpt_reg < rs) && (dpt_reg > neg_rs);
        flags.box_all   = dmax_reg < 0;
        flags.box_any   = dmin_reg < 0;
    end

endmodule

// ----- sv/fcc_verdict.sv -----
// ----------------------------------------------------------------------------
// fcc_verdict
// Merges the six per-plane outcomes into one registered verdict.
// ----------------------------------------------------------------------------
module fcc_verdict
    import fcc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         valid,
    input  logic [1:0]   command,
    input  plane_flags_t flags [NUM_PLANES],
    output logic         done,
    output logic [1:0]   verdict
);

    logic       any_pt, any_sph_out, any_cross, any_box_all, any_box_any;
    logic [1:0] verdict_next;
    logic       done_reg;
    logic [1:0] verdict_reg;

    // reduce across planes
    always_comb
    begin
        any_pt      = 1'b0;
        any_sph_out = 1'b0;
        any_cross   = 1'b0;
        any_box_all = 1'b0;
        any_box_any = 1'b0;
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            any_pt      = any_pt      | flags[i].pt_below;
            any_sph_out = any_sph_out | flags[i].sph_out;
            any_cross   = any_cross   | flags[i].sph_cross;
            any_box_all = any_box_all | flags[i].box_all;
            any_box_any = any_box_any | flags[i].box_any;
        end
    end

    // outside wins over intersects; unused command reads as inside
    always_comb
    begin
        verdict_next = VERDICT_INSIDE;
        unique case (command)
            CMD_POINT:
            begin
                if (any_pt)
                    verdict_next = VERDICT_OUTSIDE;
            end
            CMD_SPHERE:
            begin
                if (any_sph_out)
                    verdict_next = VERDICT_OUTSIDE;
                else if (any_cross)
                    verdict_next = VERDICT_INTERSECTS;
            end
            CMD_BOX:
            begin
                if (any_box_all)
                    verdict_next = VERDICT_OUTSIDE;
                else if (any_box_any)
                    verdict_next = VERDICT_INTERSECTS;
            end
            default: verdict_next = VERDICT_INSIDE;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
    end

    assign done    = done_reg;
    assign verdict = verdict_reg;

endmodule

// ----- sv/frustum_cull_classifier_top.sv -----
// ----------------------------------------------------------------------------
// frustum_cull_classifier_top
// Classifies a point, sphere or box against six frustum planes.
// ----------------------------------------------------------------------------
// The block takes one query in every cycle (busy never rises) and returns one
// verdict word per query, in order, through an input register, a multiply
// stage (one 16x16 product per axis and bound for each plane), a distance-sum
// stage, then the compare-and-merge stage that drives the output register.
// The done strobe is high for exactly one cycle per verdict and cannot be held
// off. Planes are written over APB at byte address 8*i and must be loaded
// while no query is in flight.
// ----------------------------------------------------------------------------
module frustum_cull_classifier_top
    import fcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PLANE_W-1:0] pwdata,
    output logic [PLANE_W-1:0] prdata,
    output logic               pready,
    // query
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  coord_t             first_x,
    input  coord_t             first_y,
    input  coord_t             first_z,
    input  coord_t             second_x,
    input  coord_t             second_y,
    input  coord_t             second_z,
    input  logic [RADIUS_W-1:0] radius,
    // result
    output logic               done,
    output logic [1:0]         verdict
);

    plane_t               planes [NUM_PLANES];
    plane_flags_t         flags  [NUM_PLANES];
    logic                 accept;
    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [1:0]           s1_cmd_reg, s2_cmd_reg, s3_cmd_reg;
    logic [RADIUS_W-1:0]  s1_radius_reg, s2_radius_reg, s3_radius_reg;
    coord_t               lo_reg [NUM_AXES];
    coord_t               hi_reg [NUM_AXES];
    dist_t                rs;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    fcc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // input register and side-band pipe for command and radius
    always_ff @(posedge clk)
    begin
        lo_reg[0]     <= first_x;
        lo_reg[1]     <= first_y;
        lo_reg[2]     <= first_z;
        hi_reg[0]     <= second_x;
        hi_reg[1]     <= second_y;
        hi_reg[2]     <= second_z;
        s1_cmd_reg    <= command;
        s1_radius_reg <= radius;
        s2_cmd_reg    <= s1_cmd_reg;
        s2_radius_reg <= s1_radius_reg;
        s3_cmd_reg    <= s2_cmd_reg;
        s3_radius_reg <= s2_radius_reg;
    end

    // radius at the distance scale
    assign rs = {{(DIST_W-RADIUS_W-FRAC_SHIFT){1'b0}}, s3_radius_reg, {FRAC_SHIFT{1'b0}}};

    for (genvar g = 0; g < NUM_PLANES; g++)
    begin : g_plane
        fcc_plane_unit u_plane (
            .clk   (clk),
            .plane (planes[g]),
            .lo    (lo_reg),
            .hi    (hi_reg),
            .rs    (rs),
            .flags (flags[g])
        );
    end

    fcc_verdict u_verdict (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (s3_valid_reg),
        .command (s3_cmd_reg),
        .flags   (flags),
        .done    (done),
        .verdict (verdict)
    );

    // every accepted word is taken as a verdict
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("accepted word produced no verdict");

    // no verdict without a matching accept
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 4))
        else $error("verdict without an accepted word");

    // verdict code is always a defined one
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (verdict == VERDICT_INSIDE || verdict == VERDICT_INTERSECTS ||
                  verdict == VERDICT_OUTSIDE))
        else $error("undefined verdict code");

    // a point never intersects
    a_point: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_cmd_reg == CMD_POINT) |=> verdict != VERDICT_INTERSECTS)
        else $error("point query reported intersects");

endmodule

// ----- test/frustum_cull_classifier_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frustum_cull_classifier_top_tb
// Self-checking testbench for the six-plane frustum classifier.
// ----------------------------------------------------------------------------
// Loads plane sets over APB and sends point, sphere and box queries with
// random start gaps. An untimed classifier in this file predicts the verdict
// of every accepted query. Each verdict word is checked in order against that
// prediction. Directed cases cover the plane boundaries, zero and full radius,
// swapped box bounds and the unused command. The random part runs well-formed
// frusta, extreme plane words and fully random planes.
// ----------------------------------------------------------------------------
module frustum_cull_classifier_top_tb;
    import fcc_pkg::*;

    localparam int     CLK_HALF     = 5;
    localparam int     PIPE_DEPTH   = 3;
    localparam int     IDLE_PCT     = 28;
    localparam int     MAX_REPORTS  = 10;
    localparam int     NUM_CORNERS  = 8;
    localparam int     REG_SHIFT    = 3;
    localparam int     Q88_ONE      = 256;
    localparam int     Q114_ONE     = 16384;
    localparam int     COORD_MAX    = 32767;
    localparam int     COORD_MIN    = -32768;
    localparam int     RADIUS_MAX   = 32767;
    localparam longint OFFSET_SCALE = longint'(1) << FRAC_SHIFT;

    localparam logic [1:0]          CMD_UNUSED   = 2'd3;
    localparam logic [PINDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [PINDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [1:0]          cmd;
        coord_t              fx, fy, fz;
        coord_t              sx, sy, sz;
        logic [RADIUS_W-1:0] rad;
    } query_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    plane_t              pwdata   = '0;
    logic [PLANE_W-1:0]  prdata;
    logic                pready;
    logic                start    = 1'b0;
    logic                busy;
    logic [1:0]          command  = '0;
    coord_t              first_x  = '0;
    coord_t              first_y  = '0;
    coord_t              first_z  = '0;
    coord_t              second_x = '0;
    coord_t              second_y = '0;
    coord_t              second_z = '0;
    logic [RADIUS_W-1:0] radius   = '0;
    logic                done;
    logic [1:0]          verdict;

    // model copy of the plane registers and the verdicts still in flight
    plane_t     plane_regs [NUM_PLANES] = '{default: '0};
    logic [1:0] pending_verdicts [$];
    logic [1:0] oldest_verdict;
    int         mismatch_count = 0;
    bit         gaps_on        = 1'b1;

    frustum_cull_classifier_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .start    (start),
        .busy     (busy),
        .command  (command),
        .first_x  (first_x),
        .first_y  (first_y),
        .first_z  (first_z),
        .second_x (second_x),
        .second_y (second_y),
        .second_z (second_z),
        .radius   (radius),
        .done     (done),
        .verdict  (verdict)
    );

    always #CLK_HALF clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("** frustum_cull_classifier_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Verdict prediction
    // ------------------------------------------------------------------

    // exact signed distance at 22 fraction bits
    function automatic longint plane_distance(input plane_t p, input coord_t x,
                                              input coord_t y, input coord_t z);
        longint a, b, c, d;
        a = longint'($signed(p[15:0]));
        b = longint'($signed(p[31:16]));
        c = longint'($signed(p[47:32]));
        d = longint'($signed(p[63:48]));
        return a * longint'(x) + b * longint'(y) + c * longint'(z) + d * OFFSET_SCALE;
    endfunction

    function automatic logic [1:0] classify(input query_t q);
        longint dist_val, reach;
        logic   outside, crossing, all_in;
        int     below;
        coord_t cx, cy, cz;
        outside  = 1'b0;
        crossing = 1'b0;
        all_in   = 1'b1;
        reach    = longint'(q.rad) * OFFSET_SCALE;
        case (q.cmd)
            CMD_POINT:
            begin
                for (int i = 0; i < NUM_PLANES; i++)
                    if (plane_distance(plane_regs[i], q.fx, q.fy, q.fz) < 0)
                        outside = 1'b1;
                return outside ? VERDICT_OUTSIDE : VERDICT_INSIDE;
            end
            CMD_SPHERE:
            begin
                // every plane counts, so a later outside overrides a crossing
                for (int i = 0; i < NUM_PLANES; i++)
                begin
                    dist_val = plane_distance(plane_regs[i], q.fx, q.fy, q.fz);
                    if (dist_val < -reach)
                        outside = 1'b1;
                    if ((dist_val < 0 ? -dist_val : dist_val) < reach)
                        crossing = 1'b1;
                end
                return outside ? VERDICT_OUTSIDE
                               : (crossing ? VERDICT_INTERSECTS : VERDICT_INSIDE);
            end
            CMD_BOX:
            begin
                // corners are formed from the bounds as given, never swapped
                for (int i = 0; i < NUM_PLANES; i++)
                begin
                    below = 0;
                    for (int k = 0; k < NUM_CORNERS; k++)
                    begin
                        cx = (k & 1) ? q.sx : q.fx;
                        cy = (k & 2) ? q.sy : q.fy;
                        cz = (k & 4) ? q.sz : q.fz;
                        if (plane_distance(plane_regs[i], cx, cy, cz) < 0)
                            below++;
                    end
                    if (below == NUM_CORNERS)
                        outside = 1'b1;
                    if (below != 0)
                        all_in = 1'b0;
                end
                return outside ? VERDICT_OUTSIDE
                               : (all_in ? VERDICT_INSIDE : VERDICT_INTERSECTS);
            end
            default:
                return VERDICT_INSIDE;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Query and plane builders
    // ------------------------------------------------------------------

    function automatic int rand_span(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic query_t make_query(input logic [1:0] cmd,
                                          input int fx, fy, fz, sx, sy, sz, rad);
        query_t q;
        q.cmd = cmd;
        q.fx  = coord_t'(fx);
        q.fy  = coord_t'(fy);
        q.fz  = coord_t'(fz);
        q.sx  = coord_t'(sx);
        q.sy  = coord_t'(sy);
        q.sz  = coord_t'(sz);
        q.rad = rad[RADIUS_W-1:0];
        return q;
    endfunction

    // any bit pattern in every field, unused command included
    function automatic query_t noise_query();
        return make_query(2'($urandom_range(int'(CMD_UNUSED), int'(CMD_POINT))),
                          $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
    endfunction

    // a query sized to land around a frustum near the origin
    function automatic query_t shaped_query();
        query_t q;
        int     lo [3];
        int     hi [3];
        int     swap_tmp;
        q = noise_query();
        q.cmd = 2'($urandom_range(int'(CMD_BOX), int'(CMD_POINT)));
        for (int j = 0; j < 3; j++)
        begin
            lo[j] = rand_span(48 * Q88_ONE);
            hi[j] = lo[j] + int'($urandom_range(40 * Q88_ONE));
            if ($urandom_range(9) == 0)
            begin
                swap_tmp = lo[j];
                lo[j]    = hi[j];
                hi[j]    = swap_tmp;
            end
        end
        q.fx = coord_t'(lo[0]);
        q.fy = coord_t'(lo[1]);
        q.fz = coord_t'(lo[2]);
        if (q.cmd == CMD_BOX)
        begin
            q.sx = coord_t'(hi[0]);
            q.sy = coord_t'(hi[1]);
            q.sz = coord_t'(hi[2]);
        end
        q.rad = ($urandom_range(9) == 0) ? '0 : RADIUS_W'($urandom_range(24 * Q88_ONE));
        return q;
    endfunction

    function automatic plane_t pack_plane(input int a, b, c, d);
        return {d[15:0], c[15:0], b[15:0], a[15:0]};
    endfunction

    // ------------------------------------------------------------------
    // Bus tasks
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // idle at random, hold start until the word is taken, then record its verdict
    task automatic send_query(input query_t q);
        while (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        command  <= q.cmd;
        first_x  <= q.fx;
        first_y  <= q.fy;
        first_z  <= q.fz;
        second_x <= q.sx;
        second_y <= q.sy;
        second_z <= q.sz;
        radius   <= q.rad;
        do @(posedge clk); while (busy);
        pending_verdicts.push_back(classify(q));
    endtask

    // stop sending and let the pipeline empty
    task automatic drain_verdicts();
        start <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 1) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PINDEX_W-1:0] index, input plane_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(index) << REG_SHIFT;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (index < NUM_PLANES)
            plane_regs[index] = value;
    endtask

    task automatic apb_read(input logic [PINDEX_W-1:0] index, output plane_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'(index) << REG_SHIFT;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        value = prdata;
    endtask

    task automatic apb_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_plane_set(input plane_t set [NUM_PLANES]);
        drain_verdicts();
        for (int i = 0; i < NUM_PLANES; i++)
            apb_write(PINDEX_W'(i), set[i]);
        apb_idle();
    endtask

    // axis-aligned cube, half size in Q8.8
    task automatic load_cube(input int half);
        plane_t set [NUM_PLANES];
        set[REG_LEFT]   = pack_plane(Q114_ONE, 0, 0, half);
        set[REG_RIGHT]  = pack_plane(-Q114_ONE, 0, 0, half);
        set[REG_BOTTOM] = pack_plane(0, Q114_ONE, 0, half);
        set[REG_TOP]    = pack_plane(0, -Q114_ONE, 0, half);
        set[REG_NEAR]   = pack_plane(0, 0, Q114_ONE, half);
        set[REG_FAR]    = pack_plane(0, 0, -Q114_ONE, half);
        load_plane_set(set);
    endtask

    // tilted planes facing inward, enclosing a region around the origin
    task automatic load_random_frustum();
        plane_t set [NUM_PLANES];
        int     n [3];
        int     axis;
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            axis = i / 2;
            for (int j = 0; j < 3; j++)
                n[j] = rand_span(Q114_ONE / 4);
            n[axis] = int'($urandom_range(Q114_ONE, Q114_ONE / 2));
            if (i % 2)
                n[axis] = -n[axis];
            set[i] = pack_plane(n[0], n[1], n[2],
                                $urandom_range(32 * Q88_ONE, 4 * Q88_ONE));
        end
        load_plane_set(set);
    endtask

    // ------------------------------------------------------------------
    // Verdict checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
                note_mismatch("verdict word with no query pending", '0, 64'(verdict));
            else
            begin
                oldest_verdict = pending_verdicts.pop_front();
                if (verdict !== oldest_verdict)
                    note_mismatch("verdict", 64'(oldest_verdict), 64'(verdict));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // zero planes put every distance at zero
    task automatic test_reset_planes();
        send_query(make_query(CMD_POINT, COORD_MIN, COORD_MAX, 0, 0, 0, 0, 0));
        send_query(make_query(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_query(CMD_SPHERE, 0, 0, 0, 0, 0, 0, Q88_ONE));
        send_query(make_query(CMD_BOX, -Q88_ONE, -Q88_ONE, -Q88_ONE,
                              Q88_ONE, Q88_ONE, Q88_ONE, 0));
        send_query(make_query(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0));
        drain_verdicts();
    endtask

    // write every plane, poke the spare slots, read the planes back
    task automatic test_plane_registers();
        plane_t readback;
        load_cube(16 * Q88_ONE);
        apb_write(REG_SPARE_LO, {PLANE_W{1'b1}});
        apb_write(REG_SPARE_HI, {PLANE_W{1'b1}});
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            apb_read(PINDEX_W'(i), readback);
            if (readback !== plane_regs[i])
                note_mismatch("plane readback", plane_regs[i], readback);
        end
        apb_idle();
    endtask

    // boundaries against a cube of half size 16
    task automatic test_directed_cases();
        int h, r;
        h = 16 * Q88_ONE;
        r = Q88_ONE;
        load_cube(h);
        // points: inside, on a plane, just past it, extremes
        send_query(make_query(CMD_POINT, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_query(CMD_POINT, -h, 0, 0, 0, 0, 0, 0));
        send_query(make_query(CMD_POINT, -h - 1, 0, 0, 0, 0, 0, 0));
        send_query(make_query(CMD_POINT, 0, h, -h, COORD_MAX, COORD_MIN, COORD_MAX,
                              RADIUS_MAX));
        send_query(make_query(CMD_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0));
        send_query(make_query(CMD_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 0));
        // spheres: zero radius, exact touch from outside, crossing, largest radius
        send_query(make_query(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0));
        send_query(make_query(CMD_SPHERE, -h - 1, 0, 0, 0, 0, 0, 0));
        send_query(make_query(CMD_SPHERE, -h - r, 0, 0, 0, 0, 0, r));
        send_query(make_query(CMD_SPHERE, -h - r - 1, 0, 0, 0, 0, 0, r));
        send_query(make_query(CMD_SPHERE, h - r / 2, 0, 0, COORD_MIN, COORD_MIN,
                              COORD_MIN, r));
        send_query(make_query(CMD_SPHERE, 0, 0, 0, 0, 0, 0, RADIUS_MAX));
        send_query(make_query(CMD_SPHERE, COORD_MIN, COORD_MAX, 0, 0, 0, 0, RADIUS_MAX));
        // boxes: inside, straddling, outside, swapped bounds, whole range
        send_query(make_query(CMD_BOX, -h / 2, -h / 2, -h / 2, h / 2, h / 2, h / 2, 0));
        send_query(make_query(CMD_BOX, -h - r, -r, -r, 0, r, r, 0));
        send_query(make_query(CMD_BOX, h + 1, -r, -r, h + 4 * r, r, r, RADIUS_MAX));
        send_query(make_query(CMD_BOX, h / 2, h / 2, h / 2, -h / 2, -h / 2, -h / 2, 0));
        send_query(make_query(CMD_BOX, h + r, 0, 0, -h - r, 0, 0, 0));
        send_query(make_query(CMD_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                              COORD_MAX, COORD_MAX, COORD_MAX, 0));
        send_query(make_query(CMD_BOX, h + 1, h + 1, h + 1, h + 1, h + 1, h + 1, 0));
        send_query(make_query(CMD_BOX, -h, -h, -h, h, h, h, 0));
        // unused command
        send_query(make_query(CMD_UNUSED, COORD_MAX, COORD_MIN, COORD_MAX,
                              COORD_MIN, COORD_MAX, COORD_MIN, RADIUS_MAX));
        send_query(make_query(CMD_UNUSED, -h - 1, 0, 0, 0, 0, 0, 0));
        drain_verdicts();
    endtask

    // well-formed frusta; one phase without gaps, one with a full drain
    task automatic test_random_frustums();
        for (int phase = 0; phase < 5; phase++)
        begin
            load_random_frustum();
            gaps_on = (phase != 1);
            for (int n = 0; n < 260; n++)
            begin
                if (phase == 3 && n == 130)
                    drain_verdicts();
                send_query(($urandom_range(99) < 85) ? shaped_query() : noise_query());
            end
        end
        gaps_on = 1'b1;
    endtask

    // plane words at the ends of their range
    task automatic test_extreme_planes();
        plane_t set [NUM_PLANES];
        for (int phase = 0; phase < 4; phase++)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
                case (phase)
                    0: set[i] = pack_plane(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
                    1: set[i] = pack_plane(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
                    2: set[i] = {PLANE_W{1'b1}};
                    default:
                        set[i] = (i % 2) ? pack_plane(COORD_MIN, COORD_MAX, COORD_MIN,
                                                      COORD_MAX)
                                         : pack_plane(COORD_MAX, COORD_MIN, COORD_MAX,
                                                      COORD_MIN);
                endcase
            load_plane_set(set);
            for (int n = 0; n < 80; n++)
                send_query(($urandom_range(1) == 0) ? shaped_query() : noise_query());
        end
    endtask

    // arbitrary 64-bit plane registers
    task automatic test_random_planes();
        plane_t set [NUM_PLANES];
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
                set[i] = {$urandom, $urandom};
            load_plane_set(set);
            for (int n = 0; n < 100; n++)
                send_query(($urandom_range(1) == 0) ? shaped_query() : noise_query());
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_planes();
        test_plane_registers();
        test_directed_cases();
        test_random_frustums();
        test_extreme_planes();
        test_random_planes();
        drain_verdicts();
        if (mismatch_count == 0)
            $display("** frustum_cull_classifier_top: PASSED **");
        else
            $display("** frustum_cull_classifier_top: FAILED **");
        $finish;
    end

endmodule
